@@ rtl/ups_pkg.sv @@
// ----------------------------------------------------------------------------
// ups_pkg: shared types and constants for the unicycle PD state propagator
// Fixed-point formats, pipeline depths, register map and the CORDIC table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ups_pkg;

	// number formats
	localparam int FRAC_BITS = 16;
	localparam int TRIG_BITS = 20;

	// CORDIC: 24 rotations, four to a stage
	localparam int CORDIC_STEPS     = 24;
	localparam int CORDIC_PER_STAGE = 4;
	localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;

	// turn-rate divider: 21 quotient bits, three to a stage
	localparam int DIV_BITS      = 21;
	localparam int DIV_PER_STAGE = 3;
	localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

	// pipeline depths of the top level
	localparam int PIPE_DEPTH = 25;
	localparam int SIDE_DEPTH = 22;
	localparam int TRIG_DEPTH = 6;
	localparam int POS_DEPTH  = 8;

	// angles at 30 fractional bits for the CORDIC
	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// pi at FRAC_BITS fractional bits, rounded
	localparam int PI_F = 205887;

	// register map
	typedef enum logic [2:0] {
		REG_GAIN_POS    = 3'd0,
		REG_GAIN_VEL    = 3'd1,
		REG_ACCEL_LIMIT = 3'd2,
		REG_TURN_LIMIT  = 3'd3,
		REG_SURGE_MIN   = 3'd4,
		REG_SURGE_MAX   = 3'd5,
		REG_STEP_TIME   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [16:0] gain_pos;
		logic [16:0] gain_vel;
		logic [19:0] accel_limit;
		logic [19:0] turn_limit;
		logic [19:0] surge_min;
		logic [19:0] surge_max;
		logic [16:0] step_time;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain_pos:    17'd2071,
		gain_vel:    17'd20015,
		accel_limit: 20'd7864,
		turn_limit:  20'd32768,
		surge_min:   20'd6554,
		surge_max:   20'd327680,
		step_time:   17'd6554
	};

	// arctangent of 2^-i at 30 fractional bits
	function automatic logic signed [34:0] atan_q30(input int idx);
		logic signed [34:0] v;
		unique case (idx)
			0:  v = 35'sd843314857;
			1:  v = 35'sd497837829;
			2:  v = 35'sd263043837;
			3:  v = 35'sd133525159;
			4:  v = 35'sd67021687;
			5:  v = 35'sd33543516;
			6:  v = 35'sd16775851;
			7:  v = 35'sd8388437;
			8:  v = 35'sd4194283;
			9:  v = 35'sd2097149;
			10: v = 35'sd1048576;
			11: v = 35'sd524288;
			12: v = 35'sd262144;
			13: v = 35'sd131072;
			14: v = 35'sd65536;
			15: v = 35'sd32768;
			16: v = 35'sd16384;
			17: v = 35'sd8192;
			18: v = 35'sd4096;
			19: v = 35'sd2048;
			20: v = 35'sd1024;
			21: v = 35'sd512;
			22: v = 35'sd256;
			23: v = 35'sd128;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/ups_regs.sv @@
// ----------------------------------------------------------------------------
// ups_regs: configuration register file
// Decodes the write port and holds the control gains, limits and step time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ups_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [19:0]   cfg_wdata,
	output ups_pkg::cfg_t cfg
);
	import ups_pkg::*;

	cfg_t cfg_q;

	// decode the index and load the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_GAIN_POS:    cfg_q.gain_pos    <= cfg_wdata[16:0];
				REG_GAIN_VEL:    cfg_q.gain_vel    <= cfg_wdata[16:0];
				REG_ACCEL_LIMIT: cfg_q.accel_limit <= cfg_wdata;
				REG_TURN_LIMIT:  cfg_q.turn_limit  <= cfg_wdata;
				REG_SURGE_MIN:   cfg_q.surge_min   <= cfg_wdata;
				REG_SURGE_MAX:   cfg_q.surge_max   <= cfg_wdata;
				REG_STEP_TIME:   cfg_q.step_time   <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/ups_cordic.sv @@
// ----------------------------------------------------------------------------
// ups_cordic: pipelined sine and cosine
// Wraps and folds a Q3.16 angle, runs 24 rotations at 30 fractional bits
// over six stages and rounds to 20 fractional bits. Eight register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ups_cordic (
	input  logic               clk,
	input  logic signed [18:0] angle,
	output logic signed [21:0] cos_val,
	output logic signed [21:0] sin_val
);
	import ups_pkg::*;

	logic signed [34:0] z_wr, z_fd;
	logic               neg_fd;

	// rotation state per stage; index 1 is the folded angle
	logic signed [33:0] x_st   [1:CORDIC_STAGES+1];
	logic signed [33:0] y_st   [1:CORDIC_STAGES+1];
	logic signed [34:0] z_st   [1:CORDIC_STAGES+1];
	logic               neg_st [1:CORDIC_STAGES+1];

	logic signed [33:0] x_nx [CORDIC_STAGES];
	logic signed [33:0] y_nx [CORDIC_STAGES];
	logic signed [34:0] z_nx [CORDIC_STAGES];

	logic signed [33:0] xr, yr, xsh, ysh;
	logic signed [21:0] xc, yc;

	// wrap into (-pi, pi], then fold into [-pi/2, pi/2]
	always_comb begin
		z_wr = {{2{angle[18]}}, angle, 14'b0};
		if (z_wr > PI_Q30) begin
			z_wr = z_wr - TWO_PI_Q30;
		end else if (z_wr <= -PI_Q30) begin
			z_wr = z_wr + TWO_PI_Q30;
		end
		z_fd   = z_wr;
		neg_fd = 1'b0;
		if (z_wr > HALF_PI_Q30) begin
			z_fd   = z_wr - PI_Q30;
			neg_fd = 1'b1;
		end else if (z_wr < -HALF_PI_Q30) begin
			z_fd   = z_wr + PI_Q30;
			neg_fd = 1'b1;
		end
	end

	// four rotations per stage
	always_comb begin
		logic signed [33:0] xt, yt, xn;
		logic signed [34:0] zt;
		int i;
		for (int g = 0; g < CORDIC_STAGES; g++) begin
			xt = x_st[g+1];
			yt = y_st[g+1];
			zt = z_st[g+1];
			for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
				i = g * CORDIC_PER_STAGE + j;
				if (zt >= 0) begin
					xn = xt - (yt >>> i);
					yt = yt + (xt >>> i);
					zt = zt - atan_q30(i);
				end else begin
					xn = xt + (yt >>> i);
					yt = yt - (xt >>> i);
					zt = zt + atan_q30(i);
				end
				xt = xn;
			end
			x_nx[g] = xt;
			y_nx[g] = yt;
			z_nx[g] = zt;
		end
	end

	// advance the rotation pipeline
	always_ff @(posedge clk) begin
		x_st[1]   <= CORDIC_GAIN;
		y_st[1]   <= '0;
		z_st[1]   <= z_fd;
		neg_st[1] <= neg_fd;
		for (int g = 0; g < CORDIC_STAGES; g++) begin
			x_st[g+2]   <= x_nx[g];
			y_st[g+2]   <= y_nx[g];
			z_st[g+2]   <= z_nx[g];
			neg_st[g+2] <= neg_st[g+1];
		end
	end

	// round half up to 20 fractional bits and undo the fold
	always_comb begin
		xr  = x_st[CORDIC_STAGES+1] + 34'sd512;
		yr  = y_st[CORDIC_STAGES+1] + 34'sd512;
		xsh = xr >>> 10;
		ysh = yr >>> 10;
		xc  = 22'(xsh);
		yc  = 22'(ysh);
	end

	always_ff @(posedge clk) begin
		cos_val <= neg_st[CORDIC_STAGES+1] ? -xc : xc;
		sin_val <= neg_st[CORDIC_STAGES+1] ? -yc : yc;
	end

endmodule

@@ rtl/ups_divider.sv @@
// ----------------------------------------------------------------------------
// ups_divider: pipelined saturating turn-rate divider
// Divides the lateral term, shifted up by the fraction width, by the surge
// speed, truncating toward zero, and clamps to the turn limit. Restoring
// division, three quotient bits per stage. Nine register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ups_divider (
	input  logic               clk,
	input  logic signed [38:0] lat,
	input  logic [19:0]        dvs,
	input  logic [19:0]        limit,
	output logic signed [20:0] turn
);
	import ups_pkg::*;

	logic [38:0] mag;
	logic [19:0] d_in;

	// per-stage divider state; index 0 is the set-up stage
	logic [19:0]         r_st   [0:DIV_STAGES];
	logic [DIV_BITS-1:0] q_st   [0:DIV_STAGES];
	logic [DIV_BITS-1:0] nb_st  [0:DIV_STAGES];
	logic [19:0]         d_st   [0:DIV_STAGES];
	logic                ovf_st [0:DIV_STAGES];
	logic                sgn_st [0:DIV_STAGES];

	logic [19:0]         r_nx  [DIV_STAGES];
	logic [DIV_BITS-1:0] q_nx  [DIV_STAGES];
	logic [DIV_BITS-1:0] nb_nx [DIV_STAGES];

	logic [DIV_BITS:0] qm;
	logic [19:0]       t;

	// magnitude and zero-surge guard; the overflow check is registered below
	always_comb begin
		mag  = lat[38] ? 39'(-lat) : 39'(lat);
		d_in = (dvs == '0) ? 20'd1 : dvs;
	end

	// three restoring steps per stage
	always_comb begin
		logic [20:0]         r2;
		logic [19:0]         rt;
		logic [DIV_BITS-1:0] qt, nt;
		for (int g = 0; g < DIV_STAGES; g++) begin
			rt = r_st[g];
			qt = q_st[g];
			nt = nb_st[g];
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				r2 = {rt, nt[DIV_BITS-1]};
				nt = {nt[DIV_BITS-2:0], 1'b0};
				if (r2 >= {1'b0, d_st[g]}) begin
					r2 = r2 - {1'b0, d_st[g]};
					qt = {qt[DIV_BITS-2:0], 1'b1};
				end else begin
					qt = {qt[DIV_BITS-2:0], 1'b0};
				end
				rt = r2[19:0];
			end
			r_nx[g]  = rt;
			q_nx[g]  = qt;
			nb_nx[g] = nt;
		end
	end

	// advance the division pipeline
	always_ff @(posedge clk) begin
		r_st[0]   <= mag[24:5];
		q_st[0]   <= '0;
		nb_st[0]  <= {mag[4:0], {FRAC_BITS{1'b0}}};
		d_st[0]   <= d_in;
		ovf_st[0] <= (mag >= {14'b0, d_in, 5'b0});
		sgn_st[0] <= lat[38];
		for (int g = 0; g < DIV_STAGES; g++) begin
			r_st[g+1]   <= r_nx[g];
			q_st[g+1]   <= q_nx[g];
			nb_st[g+1]  <= nb_nx[g];
			d_st[g+1]   <= d_st[g];
			ovf_st[g+1] <= ovf_st[g];
			sgn_st[g+1] <= sgn_st[g];
		end
	end

	// saturate, clamp to the limit and restore the sign
	always_comb begin
		qm = ovf_st[DIV_STAGES] ? {1'b1, {DIV_BITS{1'b0}}} : {1'b0, q_st[DIV_STAGES]};
		t  = (qm > {2'b0, limit}) ? limit : qm[19:0];
	end

	always_ff @(posedge clk) begin
		turn <= sgn_st[DIV_STAGES] ? -$signed({1'b0, t}) : $signed({1'b0, t});
	end

endmodule

@@ rtl/unicycle_pd_state_propagator.sv @@
// ----------------------------------------------------------------------------
// unicycle_pd_state_propagator: one PD tracking step of a unicycle, Q16.16
// The done strobe of each start transfer travels along a chain of valid bits.
// Throughput: one item per cycle; busy stays low, results cannot be held off.
// The depth is set by the CORDIC (8 stages) and the turn divider (9 stages).
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unicycle_pd_state_propagator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [19:0]        cfg_wdata,
	input  logic signed [31:0] cur_x,
	input  logic signed [31:0] cur_y,
	input  logic signed [18:0] cur_yaw,
	input  logic [19:0]        cur_surge,
	input  logic signed [31:0] ref_x,
	input  logic signed [31:0] ref_y,
	input  logic signed [18:0] ref_yaw,
	input  logic [19:0]        ref_surge,
	output logic               done,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [18:0] new_yaw,
	output logic [19:0]        new_surge
);
	import ups_pkg::*;

	typedef struct packed {
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic signed [18:0] cur_yaw;
		logic [19:0]        cur_surge;
		logic [19:0]        ref_surge;
		logic signed [32:0] dpx;
		logic signed [32:0] dpy;
	} side_t;

	typedef struct packed {
		logic signed [21:0] cc;
		logic signed [21:0] sc;
	} trig_t;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic [19:0]        ns;
	} pos_t;

	localparam logic signed [19:0] YAW_PI     = 20'(PI_F);
	localparam logic signed [19:0] YAW_2PI    = 20'(2 * PI_F);
	localparam logic [22:0]        YAW_2PI_X1 = 23'(2 * PI_F);
	localparam logic [22:0]        YAW_2PI_X2 = 23'(4 * PI_F);
	localparam logic [22:0]        YAW_2PI_X4 = 23'(8 * PI_F);
	localparam logic signed [32:0] POS_MAX    = 33'sh0_7FFF_FFFF;
	localparam logic signed [32:0] POS_MIN    = -33'sh0_8000_0000;

	logic                  accept;
	cfg_t                  cfg;
	logic [PIPE_DEPTH-1:0] vld_q;

	side_t side_in;
	side_t side_s [SIDE_DEPTH];
	trig_t trig_s [TRIG_DEPTH];
	pos_t  pos_in;
	pos_t  pos_s  [POS_DEPTH];

	logic signed [21:0] cc_s8, sc_s8, cr_s8, sr_s8;
	logic signed [42:0] vcx, vcy, vrx, vry;
	logic signed [50:0] pe_x, pe_y;
	logic signed [50:0] pe_x_s9, pe_y_s9;
	logic signed [23:0] dvx_s9, dvy_s9;
	logic signed [51:0] sx, sy;
	logic signed [35:0] ax_s10, ay_s10;
	logic signed [57:0] p_cax_s11, p_say_s11, p_cay_s11, p_sax_s11;
	logic signed [58:0] fs, ls;
	logic signed [38:0] fwd_w, alim;
	logic signed [20:0] fwd_s12;
	logic signed [38:0] lat_s12;
	logic signed [38:0] sp_s13;
	logic signed [23:0] su, smin, smax;
	logic [19:0]        ns_s14, ns_s15, ns_s16;
	logic signed [42:0] pcx_s15, pcy_s15;
	logic signed [60:0] qx_s16, qy_s16;
	logic signed [32:0] px, py;
	logic signed [20:0] turn_s21;
	logic signed [38:0] ty_s22;
	logic signed [23:0] v_s23;
	logic [23:0]        ya;
	logic [22:0]        ym;
	logic signed [19:0] r_s24;
	logic signed [19:0] yr;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	ups_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
		end
	end

	// capture the item and the position errors
	always_comb begin
		side_in.cur_x     = cur_x;
		side_in.cur_y     = cur_y;
		side_in.cur_yaw   = cur_yaw;
		side_in.cur_surge = cur_surge;
		side_in.ref_surge = ref_surge;
		side_in.dpx       = 33'(ref_x) - 33'(cur_x);
		side_in.dpy       = 33'(ref_y) - 33'(cur_y);
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int k = 1; k < SIDE_DEPTH; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	ups_cordic u_cordic_cur (
		.clk     (clk),
		.angle   (cur_yaw),
		.cos_val (cc_s8),
		.sin_val (sc_s8)
	);

	ups_cordic u_cordic_ref (
		.clk     (clk),
		.angle   (ref_yaw),
		.cos_val (cr_s8),
		.sin_val (sr_s8)
	);

	// hold the current heading's trig values for later stages
	always_ff @(posedge clk) begin
		trig_s[0].cc <= cc_s8;
		trig_s[0].sc <= sc_s8;
		for (int k = 1; k < TRIG_DEPTH; k++) begin
			trig_s[k] <= trig_s[k-1];
		end
	end

	// velocities, velocity error and position term
	always_comb begin
		vcx  = $signed({1'b0, side_s[7].cur_surge}) * cc_s8;
		vcy  = $signed({1'b0, side_s[7].cur_surge}) * sc_s8;
		vrx  = $signed({1'b0, side_s[7].ref_surge}) * cr_s8;
		vry  = $signed({1'b0, side_s[7].ref_surge}) * sr_s8;
		pe_x = $signed({1'b0, cfg.gain_pos}) * side_s[7].dpx;
		pe_y = $signed({1'b0, cfg.gain_pos}) * side_s[7].dpy;
	end

	always_ff @(posedge clk) begin
		dvx_s9  <= $signed(vrx[42:TRIG_BITS]) - $signed(vcx[42:TRIG_BITS]);
		dvy_s9  <= $signed(vry[42:TRIG_BITS]) - $signed(vcy[42:TRIG_BITS]);
		pe_x_s9 <= pe_x;
		pe_y_s9 <= pe_y;
	end

	// world-frame accelerations
	always_comb begin
		sx = pe_x_s9 + $signed({1'b0, cfg.gain_vel}) * dvx_s9;
		sy = pe_y_s9 + $signed({1'b0, cfg.gain_vel}) * dvy_s9;
	end

	always_ff @(posedge clk) begin
		ax_s10 <= sx[FRAC_BITS+35:FRAC_BITS];
		ay_s10 <= sy[FRAC_BITS+35:FRAC_BITS];
	end

	// rotate into the body frame
	always_ff @(posedge clk) begin
		p_cax_s11 <= trig_s[1].cc * ax_s10;
		p_say_s11 <= trig_s[1].sc * ay_s10;
		p_cay_s11 <= trig_s[1].cc * ay_s10;
		p_sax_s11 <= trig_s[1].sc * ax_s10;
	end

	// forward and lateral terms; clamp the forward acceleration
	always_comb begin
		fs    = p_cax_s11 + p_say_s11;
		ls    = p_cay_s11 - p_sax_s11;
		fwd_w = fs[58:TRIG_BITS];
		alim  = $signed({19'b0, cfg.accel_limit});
		if (fwd_w < -alim) begin
			fwd_w = -alim;
		end
		if (fwd_w > alim) begin
			fwd_w = alim;
		end
	end

	always_ff @(posedge clk) begin
		fwd_s12 <= 21'(fwd_w);
		lat_s12 <= ls[58:TRIG_BITS];
	end

	// turn rate = lateral / surge, clamped
	ups_divider u_div (
		.clk   (clk),
		.lat   (lat_s12),
		.dvs   (side_s[11].cur_surge),
		.limit (cfg.turn_limit),
		.turn  (turn_s21)
	);

	// integrate surge and clamp: minimum first, maximum wins
	always_ff @(posedge clk) begin
		sp_s13 <= $signed({1'b0, cfg.step_time}) * fwd_s12;
	end

	always_comb begin
		smin = $signed({4'b0, cfg.surge_min});
		smax = $signed({4'b0, cfg.surge_max});
		su   = $signed({4'b0, side_s[12].cur_surge}) + $signed(sp_s13[38:FRAC_BITS]);
		if (su < smin) begin
			su = smin;
		end
		if (su > smax) begin
			su = smax;
		end
	end

	always_ff @(posedge clk) begin
		ns_s14 <= su[19:0];
	end

	// position increments
	always_ff @(posedge clk) begin
		pcx_s15 <= trig_s[5].cc * $signed({1'b0, ns_s14});
		pcy_s15 <= trig_s[5].sc * $signed({1'b0, ns_s14});
		ns_s15  <= ns_s14;
		qx_s16  <= $signed({1'b0, cfg.step_time}) * pcx_s15;
		qy_s16  <= $signed({1'b0, cfg.step_time}) * pcy_s15;
		ns_s16  <= ns_s15;
	end

	// add and saturate positions
	always_comb begin
		px = 33'(side_s[15].cur_x) + $signed(qx_s16[60:FRAC_BITS+TRIG_BITS]);
		py = 33'(side_s[15].cur_y) + $signed(qy_s16[60:FRAC_BITS+TRIG_BITS]);
		if (px > POS_MAX) begin
			px = POS_MAX;
		end else if (px < POS_MIN) begin
			px = POS_MIN;
		end
		if (py > POS_MAX) begin
			py = POS_MAX;
		end else if (py < POS_MIN) begin
			py = POS_MIN;
		end
		pos_in.nx = 32'(px);
		pos_in.ny = 32'(py);
		pos_in.ns = ns_s16;
	end

	// hold positions and surge until the heading is done
	always_ff @(posedge clk) begin
		pos_s[0] <= pos_in;
		for (int k = 1; k < POS_DEPTH; k++) begin
			pos_s[k] <= pos_s[k-1];
		end
	end

	// integrate heading
	always_ff @(posedge clk) begin
		ty_s22 <= $signed({1'b0, cfg.step_time}) * turn_s21;
		v_s23  <= 24'(side_s[21].cur_yaw) + $signed(ty_s22[38:FRAC_BITS]);
	end

	// remainder by two pi, truncating toward zero
	always_comb begin
		ya = v_s23[23] ? 24'(-v_s23) : 24'(v_s23);
		ym = ya[22:0];
		if (ym >= YAW_2PI_X4) begin
			ym = ym - YAW_2PI_X4;
		end
		if (ym >= YAW_2PI_X2) begin
			ym = ym - YAW_2PI_X2;
		end
		if (ym >= YAW_2PI_X1) begin
			ym = ym - YAW_2PI_X1;
		end
	end

	always_ff @(posedge clk) begin
		r_s24 <= v_s23[23] ? -$signed({1'b0, ym[18:0]}) : $signed({1'b0, ym[18:0]});
	end

	// fold into (-pi, pi]
	always_comb begin
		yr = r_s24;
		if (yr > YAW_PI) begin
			yr = yr - YAW_2PI;
		end else if (yr <= -YAW_PI) begin
			yr = yr + YAW_2PI;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		new_x     <= pos_s[POS_DEPTH-1].nx;
		new_y     <= pos_s[POS_DEPTH-1].ny;
		new_surge <= pos_s[POS_DEPTH-1].ns;
		new_yaw   <= yr[18:0];
	end

	assign done = vld_q[PIPE_DEPTH-1];

`ifndef ASSERT_OFF
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((20'(new_yaw) > -YAW_PI) && (20'(new_yaw) <= YAW_PI)))
		else $error("heading result outside (-pi, pi]");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_DEPTH))
		else $error("done strobe without a matching start transfer");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the unicycle PD state propagator
// Drives unicycle/reference states through the start handshake and predicts
// each result with a local integer model of the PD step, CORDIC trig,
// clamps and yaw wrap. Every done strobe is checked field by field against
// the oldest prediction. Register settings change between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import ups_pkg::*;

typedef struct {
	logic signed [31:0] cur_x;
	logic signed [31:0] cur_y;
	logic signed [18:0] cur_yaw;
	logic [19:0]        cur_surge;
	logic signed [31:0] ref_x;
	logic signed [31:0] ref_y;
	logic signed [18:0] ref_yaw;
	logic [19:0]        ref_surge;
} state_pair_t;

typedef struct {
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic signed [18:0] new_yaw;
	logic [19:0]        new_surge;
} step_result_t;

class propagation_board;
	longint       regs [7];
	step_result_t expected_q [$];
	int           errors;
	int           checked;

	function new();
		regs[REG_GAIN_POS]    = 2071;
		regs[REG_GAIN_VEL]    = 20015;
		regs[REG_ACCEL_LIMIT] = 7864;
		regs[REG_TURN_LIMIT]  = 32768;
		regs[REG_SURGE_MIN]   = 6554;
		regs[REG_SURGE_MAX]   = 327680;
		regs[REG_STEP_TIME]   = 6554;
		errors = 0;
		checked = 0;
	endfunction

	function void write_reg(reg_idx_t idx, longint v);
		if (idx == REG_GAIN_POS || idx == REG_GAIN_VEL || idx == REG_STEP_TIME)
			regs[idx] = v & 64'h1FFFF;
		else
			regs[idx] = v & 64'hFFFFF;
	endfunction

	static function longint clamp(longint v, longint lo, longint hi);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	static function longint wrap(longint v, longint pi_v);
		longint r;
		r = v % (2 * pi_v);
		if (r > pi_v) r -= 2 * pi_v;
		if (r <= -pi_v) r += 2 * pi_v;
		return r;
	endfunction

	// rotation CORDIC at 30 fractional bits, rounded to 20
	static function void sin_cos(longint ang, output longint c, output longint s);
		longint z, x, y, nx;
		bit     flip;
		z = wrap(ang <<< 14, PI_Q30);
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_q30(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_q30(i);
			end
			x = nx;
		end
		x = (x + 512) >>> 10;
		y = (y + 512) >>> 10;
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function step_result_t propagate(state_pair_t it);
		step_result_t r;
		longint cx, cy, cyaw, cs, rx, ry, ryaw, rs;
		longint cc, sc, cr, sr, ax, ay, fwd, lat, turn, ns, nx, ny, nyaw, st;
		cx = longint'(it.cur_x);
		cy = longint'(it.cur_y);
		cyaw = longint'(it.cur_yaw);
		cs = longint'(it.cur_surge);
		rx = longint'(it.ref_x);
		ry = longint'(it.ref_y);
		ryaw = longint'(it.ref_yaw);
		rs = longint'(it.ref_surge);
		st = regs[REG_STEP_TIME];
		sin_cos(cyaw, cc, sc);
		sin_cos(ryaw, cr, sr);
		// PD law in the world frame
		ax = (regs[REG_GAIN_POS] * (rx - cx) +
			regs[REG_GAIN_VEL] * (((rs * cr) >>> 20) - ((cs * cc) >>> 20))) >>> 16;
		ay = (regs[REG_GAIN_POS] * (ry - cy) +
			regs[REG_GAIN_VEL] * (((rs * sr) >>> 20) - ((cs * sc) >>> 20))) >>> 16;
		ax = clamp(ax, -(64'sd1 <<< 40), 64'sd1 <<< 40);
		ay = clamp(ay, -(64'sd1 <<< 40), 64'sd1 <<< 40);
		// rotate into the body frame
		fwd = (cc * ax + sc * ay) >>> 20;
		lat = clamp((cc * ay - sc * ax) >>> 20, -(64'sd1 <<< 38), 64'sd1 <<< 38);
		turn = (lat <<< 16) / ((cs != 0) ? cs : 64'sd1);
		fwd = clamp(fwd, -regs[REG_ACCEL_LIMIT], regs[REG_ACCEL_LIMIT]);
		turn = clamp(turn, -regs[REG_TURN_LIMIT], regs[REG_TURN_LIMIT]);
		// integrate surge, then position and heading
		ns = clamp(cs + ((st * fwd) >>> 16), regs[REG_SURGE_MIN], regs[REG_SURGE_MAX]);
		nx = clamp(cx + ((st * cc * ns) >>> 36), -64'sd2147483648, 64'sd2147483647);
		ny = clamp(cy + ((st * sc * ns) >>> 36), -64'sd2147483648, 64'sd2147483647);
		nyaw = wrap(cyaw + ((st * turn) >>> 16), PI_F);
		r.new_x = nx[31:0];
		r.new_y = ny[31:0];
		r.new_yaw = nyaw[18:0];
		r.new_surge = ns[19:0];
		return r;
	endfunction

	function void note(state_pair_t it);
		expected_q.insert(expected_q.size(), propagate(it));
	endfunction

	function void check(step_result_t got);
		step_result_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: result with nothing pending: x=%0d y=%0d yaw=%0d surge=%0d",
				$time, got.new_x, got.new_y, got.new_yaw, got.new_surge);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		checked++;
		if (got.new_x !== want.new_x) begin
			$display("%0t: new_x expected %0d actual %0d", $time, want.new_x, got.new_x);
			errors++;
		end
		if (got.new_y !== want.new_y) begin
			$display("%0t: new_y expected %0d actual %0d", $time, want.new_y, got.new_y);
			errors++;
		end
		if (got.new_yaw !== want.new_yaw) begin
			$display("%0t: new_yaw expected %0d actual %0d", $time, want.new_yaw,
				got.new_yaw);
			errors++;
		end
		if (got.new_surge !== want.new_surge) begin
			$display("%0t: new_surge expected %0d actual %0d", $time, want.new_surge,
				got.new_surge);
			errors++;
		end
	endfunction
endclass

module tb_top;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               cfg_we;
	logic [2:0]         cfg_idx;
	logic [19:0]        cfg_wdata;
	logic signed [31:0] cur_x, cur_y, ref_x, ref_y;
	logic signed [18:0] cur_yaw, ref_yaw;
	logic [19:0]        cur_surge, ref_surge;
	logic               done;
	logic signed [31:0] new_x, new_y;
	logic signed [18:0] new_yaw;
	logic [19:0]        new_surge;

	propagation_board board;
	bit               quiet;
	int               cycles;
	int               sent;

	unicycle_pd_state_propagator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.cur_x(cur_x), .cur_y(cur_y), .cur_yaw(cur_yaw), .cur_surge(cur_surge),
		.ref_x(ref_x), .ref_y(ref_y), .ref_yaw(ref_yaw), .ref_surge(ref_surge),
		.done(done), .new_x(new_x), .new_y(new_y), .new_yaw(new_yaw),
		.new_surge(new_surge)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// check each done strobe; bound the run
	always @(posedge clk) begin
		step_result_t got;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
		if (arst_n && done) begin
			got.new_x = new_x;
			got.new_y = new_y;
			got.new_yaw = new_yaw;
			got.new_surge = new_surge;
			board.check(got);
		end
	end

	task automatic write_reg(reg_idx_t idx, int unsigned v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v[19:0];
		board.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(int unsigned gp, int unsigned gv, int unsigned al,
		int unsigned tl, int unsigned smin, int unsigned smax, int unsigned st);
		write_reg(REG_GAIN_POS, gp);
		write_reg(REG_GAIN_VEL, gv);
		write_reg(REG_ACCEL_LIMIT, al);
		write_reg(REG_TURN_LIMIT, tl);
		write_reg(REG_SURGE_MIN, smin);
		write_reg(REG_SURGE_MAX, smax);
		write_reg(REG_STEP_TIME, st);
	endtask

	// present one item from a falling edge and hold it until the transfer
	task automatic send(state_pair_t it);
		bit taken;
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cur_x <= it.cur_x;
		cur_y <= it.cur_y;
		cur_yaw <= it.cur_yaw;
		cur_surge <= it.cur_surge;
		ref_x <= it.ref_x;
		ref_y <= it.ref_y;
		ref_yaw <= it.ref_yaw;
		ref_surge <= it.ref_surge;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		board.note(it);
		sent++;
	endtask

	// drop start and wait for every pending result
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (board.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [18:0] rand_yaw();
		if ($urandom_range(0, 9) == 0)
			return 19'($urandom);
		return 19'(int'($urandom_range(0, 2 * PI_F)) - PI_F);
	endfunction

	function automatic logic [19:0] rand_surge();
		unique case ($urandom_range(0, 9))
			0: return 20'($urandom);
			1: return 20'($urandom_range(0, 3));
			default: return 20'($urandom_range(1, 655360));
		endcase
	endfunction

	// mostly nearby reference states, some wide apart, some full range
	function automatic state_pair_t rand_pair();
		state_pair_t it;
		int mode;
		mode = $urandom_range(0, 9);
		it.cur_yaw = rand_yaw();
		it.ref_yaw = rand_yaw();
		it.cur_surge = rand_surge();
		it.ref_surge = rand_surge();
		if (mode < 6) begin
			it.cur_x = $signed($urandom) >>> $urandom_range(4, 14);
			it.cur_y = $signed($urandom) >>> $urandom_range(4, 14);
			it.ref_x = it.cur_x + ($signed($urandom) >>> $urandom_range(8, 20));
			it.ref_y = it.cur_y + ($signed($urandom) >>> $urandom_range(8, 20));
		end else begin
			it.cur_x = $urandom;
			it.cur_y = $urandom;
			it.ref_x = $urandom;
			it.ref_y = $urandom;
			if (mode == 9) begin
				it.cur_x = $urandom_range(0, 1) ? 32'sh7FFFFFF0 : 32'sh80000010;
				it.cur_y = $urandom_range(0, 1) ? 32'sh7FFFFFF0 : 32'sh80000010;
			end
		end
		return it;
	endfunction

	function automatic state_pair_t make_pair(int cx, int cy, int cyaw, int cs,
		int rx, int ry, int ryaw, int rs);
		state_pair_t it;
		it.cur_x = cx;
		it.cur_y = cy;
		it.cur_yaw = 19'(cyaw);
		it.cur_surge = 20'(cs);
		it.ref_x = rx;
		it.ref_y = ry;
		it.ref_yaw = 19'(ryaw);
		it.ref_surge = 20'(rs);
		return it;
	endfunction

	task automatic random_items(int n);
		for (int i = 0; i < n; i++)
			send(rand_pair());
	endtask

	initial begin
		board = new();
		quiet = 0;
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_GAIN_POS;
		cfg_wdata = '0;
		cur_x = '0;
		cur_y = '0;
		cur_yaw = '0;
		cur_surge = '0;
		ref_x = '0;
		ref_y = '0;
		ref_yaw = '0;
		ref_surge = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, angle edges, zero surge, huge errors
		send(make_pair(0, 0, 0, 65536, 0, 0, 0, 65536));
		send(make_pair(0, 0, PI_F, 65536, 100, 100, -PI_F, 0));
		send(make_pair(0, 0, -PI_F, 1, 0, 0, PI_F, 655360));
		send(make_pair(0, 0, PI_F / 2, 655360, 0, 0, -PI_F / 2, 655360));
		send(make_pair(5, -5, 262143, 0, 0, 0, -262144, 0));
		send(make_pair(0, 0, -262144, 0, 1000, -1000, 262143, 1048575));
		send(make_pair(0, 0, 0, 1048575, 0, 0, 0, 1048575));
		send(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 655360,
			32'h80000000, 32'h80000000, 0, 0));
		send(make_pair(32'h80000000, 32'h80000000, PI_F, 655360,
			32'h7FFFFFFF, 32'h7FFFFFFF, 0, 655360));
		send(make_pair(32'h7FFFFF00, 32'h80000100, PI_F / 4, 655360,
			32'h7FFFFF00, 32'h80000100, 0, 0));
		send(make_pair(32'h80000000, 32'h7FFFFFFF, -PI_F / 4, 1,
			32'h7FFFFFFF, 32'h80000000, PI_F / 3, 0));
		send(make_pair(0, 0, 205886, 3, 0, 65536, 205887, 2));
		send(make_pair(0, 0, -205886, 2, 0, -65536, -205887, 1));
		send(make_pair(-1, -1, -1, 1, -1, -1, -1, 1));
		drain();

		// crossed surge bounds: the maximum wins
		write_all(65536, 65536, 655360, 655360, 600000, 1000, 65536);
		send(make_pair(0, 0, 0, 300000, 1 << 20, 0, 0, 655360));
		send(make_pair(0, 0, PI_F, 500, 0, 1 << 20, PI_F / 2, 0));
		send(make_pair(0, 0, 100000, 0, -(1 << 24), 1 << 24, -100000, 655360));
		random_items(150);
		drain();

		// all registers at their upper bounds, but the surge minimum at 1
		write_all(65536, 65536, 655360, 655360, 1, 655360, 65536);
		random_items(250);
		drain();

		// lower bounds: zero gains and accel and turn limits, surge bounds at 1, tightest step
		write_all(0, 0, 0, 0, 1, 1, 1);
		random_items(100);
		drain();

		// defaults back, with a long stretch without gaps
		write_all(2071, 20015, 7864, 32768, 6554, 327680, 6554);
		quiet = 1;
		random_items(350);
		quiet = 0;
		random_items(200);
		drain();

		// random settings
		for (int p = 0; p < 4; p++) begin
			write_all($urandom_range(0, 65536), $urandom_range(0, 65536),
				$urandom_range(0, 655360), $urandom_range(0, 655360),
				$urandom_range(1, 20000), $urandom_range(1, 655360),
				$urandom_range(1, 65536));
			random_items(160);
			drain();
		end

		repeat (40) @(posedge clk);
		$display("tb_top: %0d items sent, %0d results checked over nine register settings",
			sent, board.checked);
		$display("tb_top: covered angle wrap, zero surge, crossed bounds and saturation");
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ups_pkg.sv
rtl/ups_regs.sv
rtl/ups_cordic.sv
rtl/ups_divider.sv
rtl/unicycle_pd_state_propagator.sv
tb/sv/tb_top.sv
